### hw/rtl/aapr_pkg.sv
`default_nettype none
package aapr_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_AXIS_X = 3'd0;
    localparam logic [2:0] REG_AXIS_Y = 3'd1;
    localparam logic [2:0] REG_AXIS_Z = 3'd2;
    localparam logic [2:0] REG_RATE   = 3'd3;
    localparam logic [2:0] REG_TSTEP  = 3'd4;
    localparam logic [2:0] REG_ATTEN  = 3'd5;

    localparam int COORD_W = 24;
    localparam int CFG_W   = 16;

    // Unit value in Q1.14
    localparam logic signed [15:0] UNIT_ONE = 16'sd16384;
    // CORDIC start value, gain already folded in (Q28)
    localparam logic signed [31:0] CORDIC_START = 32'sd163008219;
    // 2^32 / (2*pi), rounded
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam int CORDIC_STEPS = 16;

    typedef logic signed [15:0] unit_t;

    // Arctangent of 2^-i in units of 2^-24 turn
    function automatic logic signed [23:0] arc_of(input logic [3:0] i);
        logic signed [23:0] a;
        case (i)
            4'd0:    a = 24'sd2097152;
            4'd1:    a = 24'sd1238021;
            4'd2:    a = 24'sd654136;
            4'd3:    a = 24'sd332050;
            4'd4:    a = 24'sd166669;
            4'd5:    a = 24'sd83416;
            4'd6:    a = 24'sd41718;
            4'd7:    a = 24'sd20860;
            4'd8:    a = 24'sd10430;
            4'd9:    a = 24'sd5215;
            4'd10:   a = 24'sd2608;
            4'd11:   a = 24'sd1304;
            4'd12:   a = 24'sd652;
            4'd13:   a = 24'sd326;
            4'd14:   a = 24'sd163;
            default: a = 24'sd81;
        endcase
        return a;
    endfunction

    // Clamp a Q14 value to [-1, 1]
    function automatic unit_t clamp_unit(input logic signed [31:0] v);
        unit_t r;
        if (v > 32'sd16384)
            r = UNIT_ONE;
        else if (v < -32'sd16384)
            r = -UNIT_ONE;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/axis_angle_point_rotator_top.sv
`default_nettype none
// Rotates a stream of Q11.12 points about the configured axis by the angle
// rate * time_step * attenuation (Rodrigues' formula), one item per clock
// through a five-stage multiply/add pipeline; a result that waits at the
// output holds every stage and the input until it is taken.
// After reset or any write to registers 0..5 a sequential engine (squares,
// 27-step square root, three 40-step divisions, angle products, 16-step CORDIC)
// rebuilds the unit axis, sine and cosine; in_ready stays low while it runs
// unless the rate or the whole axis is zero, where points pass through
// unchanged. Results are rounded and saturated to 24 bits.
module axis_angle_point_rotator_top
    import aapr_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [2:0]                 cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [COORD_W-1:0]  point_x,
    input  wire logic signed [COORD_W-1:0]  point_y,
    input  wire logic signed [COORD_W-1:0]  point_z,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [COORD_W-1:0]       rotated_x,
    output logic signed [COORD_W-1:0]       rotated_y,
    output logic signed [COORD_W-1:0]       rotated_z
);

    typedef enum logic [3:0] {
        E_IDLE, E_SQ, E_SQRT, E_DIV_LOAD, E_DIV, E_MAG1, E_MAG2,
        E_TURN, E_PHASE, E_CORDIC, E_FINISH
    } eng_state_t;

    // Configuration registers
    logic signed [15:0] axis_reg [3];
    logic signed [15:0] rate_reg;
    logic [15:0]        tstep_reg;
    logic [15:0]        atten_reg;

    // Cached trig state
    unit_t              unit_reg [3];
    unit_t              sin_reg;
    unit_t              cos_reg;
    logic               trig_ready_reg;

    // Engine registers
    eng_state_t         state_reg;
    logic [5:0]         cnt_reg;
    logic [1:0]         lane_reg;
    logic [33:0]        norm2_reg;
    logic [53:0]        rad_reg;
    logic [53:0]        root_reg;
    logic [53:0]        bit_reg;
    logic [27:0]        rem_reg;
    logic [39:0]        num_reg;
    logic [31:0]        mag_reg;
    logic [61:0]        turn_reg;
    logic [1:0]         quad_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [23:0] cz_reg;

    logic               cfg_hit;
    logic               pass_now;

    assign cfg_hit  = cfg_we && (cfg_index == REG_AXIS_X || cfg_index == REG_AXIS_Y ||
                                 cfg_index == REG_AXIS_Z || cfg_index == REG_RATE ||
                                 cfg_index == REG_TSTEP || cfg_index == REG_ATTEN);
    assign pass_now = (rate_reg == 16'sd0) ||
                      (axis_reg[0] == 16'sd0 && axis_reg[1] == 16'sd0 &&
                       axis_reg[2] == 16'sd0);

    // Engine step logic
    logic [26:0]        root_n;
    logic signed [31:0] sq_val;
    logic [53:0]        sqrt_sum;
    logic [27:0]        rem_sh;
    logic [15:0]        abs_axis;
    logic [39:0]        quot;
    logic [15:0]        abs_rate;
    logic [62:0]        turn_rnd;
    logic [15:0]        phase_raw;
    logic [15:0]        phase;
    logic [16:0]        qsum;
    logic [1:0]         quad;
    logic [15:0]        resid;
    logic signed [31:0] xsh;
    logic signed [31:0] ysh;
    logic signed [31:0] xr;
    logic signed [31:0] yr;
    unit_t              cq;
    unit_t              sq;

    always_comb
    begin
        root_n    = root_reg[26:0];
        sq_val    = axis_reg[cnt_reg[1:0]] * axis_reg[cnt_reg[1:0]];
        sqrt_sum  = root_reg + bit_reg;
        rem_sh    = {rem_reg[26:0], num_reg[39]};
        abs_axis  = axis_reg[lane_reg][15] ? 16'(-axis_reg[lane_reg]) : axis_reg[lane_reg];
        quot      = num_reg;
        abs_rate  = rate_reg[15] ? 16'(-rate_reg) : rate_reg;
        turn_rnd  = {1'b0, turn_reg} + (63'd1 << 35);
        phase_raw = turn_rnd[51:36];
        phase     = rate_reg[15] ? 16'(16'd0 - phase_raw) : phase_raw;
        qsum      = {1'b0, phase} + 17'h2000;
        quad      = qsum[15:14];
        resid     = phase - {quad, 14'd0};
        xsh       = cx_reg >>> cnt_reg[3:0];
        ysh       = cy_reg >>> cnt_reg[3:0];
        xr        = (cx_reg + 32'sd8192) >>> 14;
        yr        = (cy_reg + 32'sd8192) >>> 14;
        cq        = clamp_unit(xr);
        sq        = clamp_unit(yr);
    end

    // Hold configuration and run the trig engine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg[0]    <= 16'sd0;
            axis_reg[1]    <= 16'sd0;
            axis_reg[2]    <= 16'sd16384;
            rate_reg       <= 16'sd0;
            tstep_reg      <= 16'd256;
            atten_reg      <= 16'd65535;
            unit_reg[0]    <= '0;
            unit_reg[1]    <= '0;
            unit_reg[2]    <= '0;
            sin_reg        <= '0;
            cos_reg        <= '0;
            trig_ready_reg <= 1'b0;
            state_reg      <= E_SQ;
            cnt_reg        <= '0;
            lane_reg       <= '0;
            norm2_reg      <= '0;
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                REG_AXIS_X: axis_reg[0] <= cfg_data;
                REG_AXIS_Y: axis_reg[1] <= cfg_data;
                REG_AXIS_Z: axis_reg[2] <= cfg_data;
                REG_RATE:   rate_reg    <= cfg_data;
                REG_TSTEP:  tstep_reg   <= cfg_data;
                default:    atten_reg   <= cfg_data;
            endcase
            trig_ready_reg <= 1'b0;
            state_reg      <= E_SQ;
            cnt_reg        <= '0;
            norm2_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                // Sum the squared axis components
                E_SQ:
                begin
                    norm2_reg <= norm2_reg + 34'(unsigned'(sq_val));
                    if (cnt_reg == 6'd2)
                    begin
                        state_reg <= E_SQRT;
                        cnt_reg   <= '0;
                        rad_reg   <= {norm2_reg + 34'(unsigned'(sq_val)), 20'd0};
                        root_reg  <= '0;
                        bit_reg   <= 54'd1 << 52;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                // Integer square root, two bits a step
                E_SQRT:
                begin
                    if (rad_reg >= sqrt_sum)
                    begin
                        rad_reg  <= rad_reg - sqrt_sum;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    if (cnt_reg == 6'd26)
                    begin
                        state_reg <= E_DIV_LOAD;
                        lane_reg  <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                E_DIV_LOAD:
                begin
                    rem_reg   <= '0;
                    num_reg   <= {abs_axis, 24'd0} + 40'(root_n >> 1);
                    cnt_reg   <= '0;
                    state_reg <= E_DIV;
                end
                // Restoring division, one quotient bit a step
                E_DIV:
                begin
                    if (cnt_reg == 6'd40)
                    begin
                        if (root_n == 27'd0)
                            unit_reg[lane_reg] <= '0;
                        else if (quot > 40'd16384)
                            unit_reg[lane_reg] <= axis_reg[lane_reg][15] ? -UNIT_ONE : UNIT_ONE;
                        else
                            unit_reg[lane_reg] <= axis_reg[lane_reg][15] ?
                                                  16'(-quot[15:0]) : quot[15:0];
                        if (lane_reg == 2'd2)
                            state_reg <= E_MAG1;
                        else
                        begin
                            lane_reg  <= lane_reg + 2'd1;
                            state_reg <= E_DIV_LOAD;
                        end
                    end
                    else
                    begin
                        if (rem_sh >= {1'b0, root_n})
                        begin
                            rem_reg <= rem_sh - {1'b0, root_n};
                            num_reg <= {num_reg[38:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            num_reg <= {num_reg[38:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                // Angle magnitude = |rate| * time_step * attenuation >> 16
                E_MAG1:
                begin
                    mag_reg   <= abs_rate * tstep_reg;
                    state_reg <= E_MAG2;
                end
                E_MAG2:
                begin
                    mag_reg   <= 32'((48'(mag_reg) * 48'(atten_reg)) >> 16);
                    state_reg <= E_TURN;
                end
                E_TURN:
                begin
                    turn_reg  <= 62'(mag_reg) * 62'(INV_TWO_PI_Q32);
                    state_reg <= E_PHASE;
                end
                // Split phase into quadrant and residual, seed CORDIC
                E_PHASE:
                begin
                    quad_reg  <= quad;
                    cx_reg    <= CORDIC_START;
                    cy_reg    <= '0;
                    cz_reg    <= {resid, 8'd0};
                    cnt_reg   <= '0;
                    state_reg <= E_CORDIC;
                end
                E_CORDIC:
                begin
                    if (!cz_reg[23])
                    begin
                        cx_reg <= cx_reg - ysh;
                        cy_reg <= cy_reg + xsh;
                        cz_reg <= cz_reg - arc_of(cnt_reg[3:0]);
                    end
                    else
                    begin
                        cx_reg <= cx_reg + ysh;
                        cy_reg <= cy_reg - xsh;
                        cz_reg <= cz_reg + arc_of(cnt_reg[3:0]);
                    end
                    if (cnt_reg == 6'(CORDIC_STEPS - 1))
                        state_reg <= E_FINISH;
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                // Round, clamp and rotate by whole quadrants
                E_FINISH:
                begin
                    case (quad_reg)
                        2'd0:
                        begin
                            cos_reg <= cq;
                            sin_reg <= sq;
                        end
                        2'd1:
                        begin
                            cos_reg <= -sq;
                            sin_reg <= cq;
                        end
                        2'd2:
                        begin
                            cos_reg <= -cq;
                            sin_reg <= -sq;
                        end
                        default:
                        begin
                            cos_reg <= sq;
                            sin_reg <= -cq;
                        end
                    endcase
                    trig_ready_reg <= 1'b1;
                    state_reg      <= E_IDLE;
                end
                default:
                    state_reg <= E_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Point pipeline
    // ------------------------------------------------------------------
    logic adv;
    logic signed [COORD_W-1:0] p_in [3];

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv && (trig_ready_reg || pass_now);
    assign p_in[0]  = point_x;
    assign p_in[1]  = point_y;
    assign p_in[2]  = point_z;

    logic [4:0]                v_reg;
    logic [4:0]                pass_reg;
    logic signed [COORD_W-1:0] p1_reg [3];
    logic signed [COORD_W-1:0] p2_reg [3];
    logic signed [COORD_W-1:0] p3_reg [3];
    logic signed [COORD_W-1:0] p4_reg [3];
    logic signed [39:0]        m1_reg [3][3];
    logic signed [39:0]        pc1_reg [3];
    logic signed [41:0]        dot2_reg;
    logic signed [41:0]        cr2_reg [3];
    logic signed [41:0]        t1_2_reg [3];
    logic signed [41:0]        t1_3_reg [3];
    logic signed [41:0]        t1_4_reg [3];
    logic signed [45:0]        t2_3_reg [3];
    logic signed [45:0]        t2_4_reg [3];
    logic signed [46:0]        dm3_reg;
    logic signed [48:0]        t3_4_reg [3];
    logic signed [COORD_W-1:0] res_reg [3];

    logic signed [29:0]        d14;
    logic signed [16:0]        omc;
    logic signed [32:0]        dm14;
    logic signed [57:0]        crs [3];
    logic signed [51:0]        acc [3];
    logic signed [35:0]        rnd [3];

    always_comb
    begin
        d14  = 30'(dot2_reg >>> 12);
        omc  = 17'sd16384 - 17'(cos_reg);
        dm14 = 33'(dm3_reg >>> 14);
        for (int i = 0; i < 3; i++)
        begin
            crs[i] = cr2_reg[i] * sin_reg;
            acc[i] = 52'(t1_4_reg[i]) + 52'(t2_4_reg[i]) + 52'(t3_4_reg[i]) + 52'sd32768;
            rnd[i] = 36'(acc[i] >>> 16);
        end
    end

    // Advance all stages together; a stall holds every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[3:0], in_valid && in_ready};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pass_reg <= {pass_reg[3:0], pass_now};
            // Stage 1: axis-by-point and point-by-cosine products
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i]  <= p_in[i];
                pc1_reg[i] <= p_in[i] * cos_reg;
                for (int j = 0; j < 3; j++)
                    m1_reg[i][j] <= unit_reg[i] * p_in[j];
            end
            // Stage 2: dot and cross products
            dot2_reg   <= 42'(m1_reg[0][0]) + 42'(m1_reg[1][1]) + 42'(m1_reg[2][2]);
            cr2_reg[0] <= 42'(m1_reg[1][2]) - 42'(m1_reg[2][1]);
            cr2_reg[1] <= 42'(m1_reg[2][0]) - 42'(m1_reg[0][2]);
            cr2_reg[2] <= 42'(m1_reg[0][1]) - 42'(m1_reg[1][0]);
            for (int i = 0; i < 3; i++)
            begin
                p2_reg[i]   <= p1_reg[i];
                t1_2_reg[i] <= 42'(pc1_reg[i]) <<< 2;
            end
            // Stage 3: cross by sine, dot by one minus cosine
            dm3_reg <= d14 * omc;
            for (int i = 0; i < 3; i++)
            begin
                p3_reg[i]   <= p2_reg[i];
                t1_3_reg[i] <= t1_2_reg[i];
                t2_3_reg[i] <= 46'(crs[i] >>> 12);
            end
            // Stage 4: axial term
            for (int i = 0; i < 3; i++)
            begin
                p4_reg[i]   <= p3_reg[i];
                t1_4_reg[i] <= t1_3_reg[i];
                t2_4_reg[i] <= t2_3_reg[i];
                t3_4_reg[i] <= dm14 * unit_reg[i];
            end
            // Stage 5: sum, round and saturate, or pass the point through unchanged
            for (int i = 0; i < 3; i++)
            begin
                if (pass_reg[3])
                    res_reg[i] <= p4_reg[i];
                else if (rnd[i] > 36'sd8388607)
                    res_reg[i] <= 24'sh7FFFFF;
                else if (rnd[i] < -36'sd8388608)
                    res_reg[i] <= 24'sh800000;
                else
                    res_reg[i] <= rnd[i][23:0];
            end
        end
    end

    assign out_valid = v_reg[4];
    assign rotated_x = res_reg[0];
    assign rotated_y = res_reg[1];
    assign rotated_z = res_reg[2];

    // Rotating items only enter with a cached angle
    a_trig_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !pass_now |-> trig_ready_reg)
        else $error("rotating item accepted before trig was ready");

    // A register write drops the cached angle
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> !trig_ready_reg)
        else $error("trig still marked ready after a register write");

    // Cached sine and cosine stay within one
    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        trig_ready_reg |-> (cos_reg <= UNIT_ONE && cos_reg >= -UNIT_ONE &&
                            sin_reg <= UNIT_ONE && sin_reg >= -UNIT_ONE))
        else $error("sine or cosine outside unit range");

endmodule
`default_nettype wire

### sim/axis_angle_point_rotator_top_tb.sv
`default_nettype none
module axis_angle_point_rotator_top_tb;
    import aapr_pkg::*;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;
    typedef struct {
        coord_t px;
        coord_t py;
        coord_t pz;
        int     cfg_sel;
        bit     typed;
        coord_t ex;
        coord_t ey;
        coord_t ez;
    } row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    coord_t            point_x;
    coord_t            point_y;
    coord_t            point_z;
    logic              out_valid;
    logic              out_ready;
    coord_t            rotated_x;
    coord_t            rotated_y;
    coord_t            rotated_z;

    axis_angle_point_rotator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rotated_x (rotated_x),
        .rotated_y (rotated_y),
        .rotated_z (rotated_z)
    );

    // Shadow copy of the registers and the cached rotation terms
    logic [15:0] shadow_reg [6];
    longint      unit_axis_q [3];
    longint      sine_q;
    longint      cosine_q;

    point_t rotated_q [$];
    int     mismatches;
    int     items_sent;
    int     items_seen;
    int     reg_writes;
    int     sender_idle_pct;
    int     receiver_stall_pct;
    int     hold_cycles;

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Watchdog
    initial
    begin
        #60000000;
        $display("axis_angle_point_rotator_top regression: fail");
        $finish;
    end

    function automatic longint unsigned root_of(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_q14(input longint v);
        longint r;
        r = v;
        if (v > 16384)
            r = 16384;
        else if (v < -16384)
            r = -16384;
        return r;
    endfunction

    // Rebuild unit axis, sine and cosine from the shadow registers
    function automatic void rebuild_trig();
        longint          a [3];
        longint unsigned norm2;
        longint unsigned n;
        longint unsigned m;
        longint unsigned u;
        longint unsigned mag;
        longint unsigned turns;
        longint unsigned phase;
        longint          rate;
        longint          x;
        longint          y;
        longint          z;
        longint          nx;
        longint          cq;
        longint          sq;
        longint          r;
        logic [15:0]     resid;
        int              q;
        norm2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = longint'($signed(shadow_reg[i]));
            norm2 = norm2 + longint'(a[i] * a[i]);
        end
        n = root_of(norm2 << 20);
        for (int i = 0; i < 3; i++)
        begin
            m = (a[i] < 0) ? -a[i] : a[i];
            u = 0;
            if (n != 0)
                u = ((m << 24) + n / 2) / n;
            if (u > 16384)
                u = 16384;
            unit_axis_q[i] = (a[i] < 0) ? -longint'(u) : longint'(u);
        end
        rate = longint'($signed(shadow_reg[REG_RATE]));
        mag = longint'((rate < 0) ? -rate : rate) * shadow_reg[REG_TSTEP]
              * shadow_reg[REG_ATTEN];
        turns = (mag >> 16) * 64'd683565276;
        phase = ((turns + (64'd1 << 35)) >> 36) & 64'hFFFF;
        if (rate < 0)
            phase = (64'h10000 - phase) & 64'hFFFF;
        q = int'(((phase + 64'h2000) >> 14) & 3);
        resid = 16'(phase - q * 64'h4000);
        r = longint'($signed(resid));
        x = 163008219;
        y = 0;
        z = r * 256;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(arc_of(i[3:0]));
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(arc_of(i[3:0]));
            end
            x = nx;
        end
        cq = clamp_q14((x + 8192) >>> 14);
        sq = clamp_q14((y + 8192) >>> 14);
        case (q)
            0: begin cosine_q = cq;  sine_q = sq;  end
            1: begin cosine_q = -sq; sine_q = cq;  end
            2: begin cosine_q = -cq; sine_q = -sq; end
            default: begin cosine_q = sq; sine_q = -cq; end
        endcase
    endfunction

    function automatic coord_t sat24(input longint v);
        longint r;
        r = v;
        if (v > 8388607)
            r = 8388607;
        else if (v < -8388608)
            r = -8388608;
        return coord_t'(r);
    endfunction

    // Rotate one point with the cached terms
    function automatic point_t rotate_point(input point_t pt);
        longint p [3];
        longint cr [3];
        longint res [3];
        longint dot;
        longint d14;
        longint omc;
        longint t1;
        longint t2;
        longint t3;
        point_t o;
        p[0] = pt.x;
        p[1] = pt.y;
        p[2] = pt.z;
        if (shadow_reg[REG_RATE] == 0 ||
            (shadow_reg[REG_AXIS_X] | shadow_reg[REG_AXIS_Y] | shadow_reg[REG_AXIS_Z]) == 0)
            return pt;
        omc = 16384 - cosine_q;
        dot = unit_axis_q[0] * p[0] + unit_axis_q[1] * p[1] + unit_axis_q[2] * p[2];
        cr[0] = unit_axis_q[1] * p[2] - unit_axis_q[2] * p[1];
        cr[1] = unit_axis_q[2] * p[0] - unit_axis_q[0] * p[2];
        cr[2] = unit_axis_q[0] * p[1] - unit_axis_q[1] * p[0];
        d14 = dot >>> 12;
        for (int i = 0; i < 3; i++)
        begin
            t1 = p[i] * cosine_q * 4;
            t2 = (cr[i] * sine_q) >>> 12;
            t3 = ((d14 * omc) >>> 14) * unit_axis_q[i];
            res[i] = (t1 + t2 + t3 + (64'sd1 <<< 15)) >>> 16;
        end
        o.x = sat24(res[0]);
        o.y = sat24(res[1]);
        o.z = sat24(res[2]);
        return o;
    endfunction

    // Receiver: random stalls, plus a long hold when asked
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            items_seen++;
            if (rotated_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item %0d %0d %0d", rotated_x, rotated_y, rotated_z);
            end
            else
            begin
                want = rotated_q.pop_front();
                if (want.x !== rotated_x || want.y !== rotated_y || want.z !== rotated_z)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d got %0d %0d %0d",
                                 want.x, want.y, want.z, rotated_x, rotated_y, rotated_z);
                end
            end
        end
    end

    // Drop the input and wait until every item has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (rotated_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Write one register; the caller drops the enable after the group
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx < 3'd6)
        begin
            shadow_reg[idx] = val;
            rebuild_trig();
        end
        reg_writes++;
    endtask

    task automatic apply_setting(input logic [15:0] ax, input logic [15:0] ay,
                                 input logic [15:0] az, input logic [15:0] rate,
                                 input logic [15:0] tstep, input logic [15:0] atten);
        wait_drained();
        write_reg(REG_AXIS_X, ax);
        write_reg(REG_AXIS_Y, ay);
        write_reg(REG_AXIS_Z, az);
        write_reg(REG_RATE, rate);
        write_reg(REG_TSTEP, tstep);
        write_reg(REG_ATTEN, atten);
        cfg_we <= 1'b0;
    endtask

    // Offer one item, hold it until taken, then idle at random
    task automatic send_point(input point_t pt, input bit typed, input point_t want);
        point_t exp_pt;
        in_valid <= 1'b1;
        point_x  <= pt.x;
        point_y  <= pt.y;
        point_z  <= pt.z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        exp_pt = typed ? want : rotate_point(pt);
        rotated_q = {rotated_q, exp_pt};
        items_sent++;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
    endtask

    function automatic coord_t rand_coord();
        coord_t v;
        v = coord_t'($urandom);
        if ($urandom_range(3) == 0)
            v = coord_t'($signed(v[15:0]));
        return v;
    endfunction

    function automatic logic [15:0] rand_reg();
        logic [15:0] v;
        case ($urandom_range(4))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // Directed rows; cfg_sel picks a register setting before the row
    localparam int NROWS = 20;
    row_t dir_rows [NROWS] = '{
        '{24'sd0, 24'sd0, 24'sd0, 0, 1'b1, 24'sd0, 24'sd0, 24'sd0},
        '{24'sd8388607, -24'sd8388608, 24'sd1, 0, 1'b1,
          24'sd8388607, -24'sd8388608, 24'sd1},
        '{-24'sd8388608, 24'sd8388607, -24'sd1, 0, 1'b1,
          -24'sd8388608, 24'sd8388607, -24'sd1},
        '{24'sd4096, 24'sd0, 24'sd0, 1, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{24'sd0, 24'sd4096, 24'sd0, 0, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{24'sd8388607, 24'sd8388607, 24'sd8388607, 0, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{-24'sd8388608, -24'sd8388608, -24'sd8388608, 0, 1'b0,
          24'sd0, 24'sd0, 24'sd0},
        '{24'sd4096, 24'sd4096, 24'sd4096, 2, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{24'sd8388607, -24'sd8388608, 24'sd8388607, 0, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{24'sd123456, -24'sd654321, 24'sd777, 3, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{-24'sd8388608, 24'sd0, 24'sd8388607, 0, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{24'sd5000, 24'sd6000, -24'sd7000, 4, 1'b1, 24'sd5000, 24'sd6000, -24'sd7000},
        '{-24'sd8388608, 24'sd8388607, 24'sd0, 0, 1'b1,
          -24'sd8388608, 24'sd8388607, 24'sd0},
        '{24'sd5000, 24'sd6000, -24'sd7000, 5, 1'b1, 24'sd5000, 24'sd6000, -24'sd7000},
        '{24'sd8388607, 24'sd1, -24'sd1, 6, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{-24'sd8388608, 24'sd8388607, 24'sd12345, 0, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{24'sd1, 24'sd2, 24'sd3, 7, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{24'sd8388607, 24'sd8388607, -24'sd8388608, 0, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{24'sd300000, -24'sd300000, 24'sd300000, 8, 1'b0, 24'sd0, 24'sd0, 24'sd0},
        '{-24'sd1, -24'sd1, -24'sd1, 0, 1'b0, 24'sd0, 24'sd0, 24'sd0}
    };

    task automatic select_setting(input int sel);
        case (sel)
            // quarter turn about z
            1: apply_setting(16'h0000, 16'h0000, 16'h4000, 16'h1922, 16'h0100, 16'hFFFF);
            // unnormalised diagonal axis, one radian
            2: apply_setting(16'h2000, 16'h2000, 16'h2000, 16'h1000, 16'h0100, 16'hFFFF);
            // most negative axis and rate, longest step
            3: apply_setting(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
            // zero rate passes points through
            4: apply_setting(16'h7FFF, 16'h1234, 16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF);
            // zero axis passes points through
            5: apply_setting(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
            // zero time step: rotation path with a zero angle
            6: apply_setting(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'hFFFF);
            // zero attenuation, then a write beyond the last register
            7:
            begin
                apply_setting(16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000);
                write_reg(3'd6, 16'hFFFF);
                write_reg(3'd7, 16'h0000);
                cfg_we <= 1'b0;
            end
            8: apply_setting(16'h7FFF, 16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h8000);
            default: ;
        endcase
    endtask

    initial
    begin
        point_t pt;
        point_t want;
        int     phase_items;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 3'd0;
        cfg_data = '0;
        in_valid = 1'b0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        out_ready = 1'b0;
        mismatches = 0;
        items_sent = 0;
        items_seen = 0;
        reg_writes = 0;
        hold_cycles = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        shadow_reg[REG_AXIS_X] = 16'd0;
        shadow_reg[REG_AXIS_Y] = 16'd0;
        shadow_reg[REG_AXIS_Z] = 16'd16384;
        shadow_reg[REG_RATE]   = 16'd0;
        shadow_reg[REG_TSTEP]  = 16'd256;
        shadow_reg[REG_ATTEN]  = 16'd65535;
        rebuild_trig();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows
        foreach (dir_rows[i])
        begin
            select_setting(dir_rows[i].cfg_sel);
            pt   = '{dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz};
            want = '{dir_rows[i].ex, dir_rows[i].ey, dir_rows[i].ez};
            send_point(pt, dir_rows[i].typed, want);
        end
        in_valid <= 1'b0;

        // Random phases with varying settings and idling
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 79; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 79; end
                default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
            endcase
            if (ph % 5 == 4)
                apply_setting(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0100, 16'hFFFF);
            else
                apply_setting(rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                              rand_reg(), rand_reg());
            if (ph == 0)
                hold_cycles = 400;
            phase_items = 80 + $urandom_range(8);
            for (int k = 0; k < phase_items; k++)
            begin
                pt = '{rand_coord(), rand_coord(), rand_coord()};
                send_point(pt, 1'b0, pt);
            end
            in_valid <= 1'b0;
        end

        // Drain and report
        receiver_stall_pct = 0;
        while (rotated_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d items in, %0d out, %0d register writes, %0d mismatches",
                 items_sent, items_seen, reg_writes, mismatches);
        if (mismatches == 0)
            $display("axis_angle_point_rotator_top regression: pass");
        else
            $display("axis_angle_point_rotator_top regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
hw/rtl/aapr_pkg.sv
hw/rtl/axis_angle_point_rotator_top.sv
sim/axis_angle_point_rotator_top_tb.sv
